// ===== design/assert_macros.svh =====
// Assertion macros for the module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define WRHP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds whenever the antecedent holds.
`define WRHP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/wrhp_pkg.sv =====
// Package with the shared types, codes and constants of the WAV header parser.
package wrhp_pkg;

    localparam int CMD_W = 2;
    localparam int BYTE_W = 8;
    localparam int STATUS_W = 3;
    localparam int TDATA_OUT_W = 176;

    localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HEADER = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DATA = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT_ID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT_SIZE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT_FORM = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_WAVE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SHORT_FMT = 3'd6;
    localparam logic [STATUS_W-1:0] ST_SKIP_END = 3'd7;

    // Four-character codes as they assemble little-endian.
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [15:0]         audio_format;
        logic [15:0]         num_channels;
        logic [31:0]         sample_rate;
        logic [31:0]         byte_rate;
        logic [15:0]         block_align;
        logic [15:0]         bits_per_sample;
        logic [31:0]         data_size;
        logic [BYTE_W-1:0]   payload_byte;
        logic                payload_valid;
    } result_t;

endpackage

// ===== design/wrhp_in_reg.sv =====
// Input register that holds one accepted transaction until the parser takes it.
module wrhp_in_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [wrhp_pkg::BYTE_W-1:0] s_tdata,
    input  logic [wrhp_pkg::CMD_W-1:0]  s_tuser,
    input  logic                       take,
    output logic                       item_valid,
    output wrhp_pkg::item_t            item
);

    logic            valid_reg;
    logic            valid_next;
    wrhp_pkg::item_t item_reg;

    assign s_tready = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.command <= s_tuser;
            item_reg.data_byte <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

// ===== design/wrhp_core.sv =====
// Parser state and the single-pass update that turns one byte or command into a result.
module wrhp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  wrhp_pkg::item_t   item,
    output wrhp_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_ID    = 3'd0,
        PH_SIZE  = 3'd1,
        PH_FORM  = 3'd2,
        PH_PROPS = 3'd3,
        PH_SKIP  = 3'd4,
        PH_XTRA  = 3'd5,
        PH_DATA  = 3'd6,
        PH_ERR   = 3'd7
    } phase_t;

    phase_t                        phase_reg;
    phase_t                        phase_next;
    logic [3:0]                    byte_count_reg;
    logic [3:0]                    byte_count_next;
    logic [31:0]                   chunk_code_reg;
    logic [31:0]                   chunk_code_next;
    logic [31:0]                   chunk_length_reg;
    logic [31:0]                   chunk_length_next;
    logic [31:0]                   skip_remaining_reg;
    logic [31:0]                   skip_remaining_next;
    logic [7:0]                    format_reg [16];
    logic [7:0]                    format_next [16];
    logic [wrhp_pkg::STATUS_W-1:0] parse_status_reg;
    logic [wrhp_pkg::STATUS_W-1:0] parse_status_next;
    logic                          pay;
    logic [31:0]                   skip_dec;
    logic [7:0]                    b;

    assign b = item.data_byte;

    always_comb
    begin
        phase_next = phase_reg;
        byte_count_next = byte_count_reg;
        chunk_code_next = chunk_code_reg;
        chunk_length_next = chunk_length_reg;
        skip_remaining_next = skip_remaining_reg;
        format_next = format_reg;
        parse_status_next = parse_status_reg;
        pay = 1'b0;
        skip_dec = (skip_remaining_reg != 32'd0) ? skip_remaining_reg - 32'd1 : 32'd0;

        case (item.command)
            wrhp_pkg::CMD_BYTE:
            begin
                unique case (phase_reg)
                    PH_ID, PH_FORM:
                    begin
                        chunk_code_next = {b, chunk_code_reg[31:8]};
                        byte_count_next = byte_count_reg + 4'd1;
                        if (byte_count_reg == 4'd3)
                        begin
                            byte_count_next = 4'd0;
                            if (phase_reg == PH_ID)
                            begin
                                phase_next = PH_SIZE;
                            end
                            else if (chunk_code_next != wrhp_pkg::ID_WAVE)
                            begin
                                parse_status_next = wrhp_pkg::ST_NOT_WAVE;
                                phase_next = PH_ERR;
                            end
                            else
                            begin
                                phase_next = PH_ID;
                            end
                        end
                    end
                    PH_SIZE:
                    begin
                        chunk_length_next = {b, chunk_length_reg[31:8]};
                        byte_count_next = byte_count_reg + 4'd1;
                        if (byte_count_reg == 4'd3)
                        begin
                            byte_count_next = 4'd0;
                            if (chunk_code_reg == wrhp_pkg::ID_RIFF)
                            begin
                                phase_next = PH_FORM;
                            end
                            else if (chunk_code_reg == wrhp_pkg::ID_FMT)
                            begin
                                phase_next = PH_PROPS;
                            end
                            else if (chunk_code_reg == wrhp_pkg::ID_DATA)
                            begin
                                phase_next = PH_DATA;
                                parse_status_next = wrhp_pkg::ST_DATA;
                            end
                            else
                            begin
                                skip_remaining_next = chunk_length_next;
                                phase_next = (chunk_length_next == 32'd0) ? PH_ID : PH_SKIP;
                            end
                        end
                    end
                    PH_PROPS:
                    begin
                        format_next[byte_count_reg] = b;
                        byte_count_next = byte_count_reg + 4'd1;
                        if (byte_count_reg == 4'd15)
                        begin
                            byte_count_next = 4'd0;
                            if (chunk_length_reg > 32'd16)
                            begin
                                skip_remaining_next = chunk_length_reg - 32'd16;
                                phase_next = PH_XTRA;
                            end
                            else
                            begin
                                phase_next = PH_ID;
                            end
                        end
                    end
                    PH_SKIP, PH_XTRA:
                    begin
                        skip_remaining_next = skip_dec;
                        if (skip_dec == 32'd0)
                        begin
                            phase_next = PH_ID;
                        end
                    end
                    PH_DATA:
                    begin
                        pay = 1'b1;
                    end
                    PH_ERR:
                    begin
                        phase_next = PH_ERR;
                    end
                endcase
            end
            wrhp_pkg::CMD_END:
            begin
                unique case (phase_reg)
                    PH_ID, PH_XTRA:
                    begin
                        parse_status_next = wrhp_pkg::ST_SHORT_ID;
                        phase_next = PH_ERR;
                    end
                    PH_SIZE:
                    begin
                        parse_status_next = wrhp_pkg::ST_SHORT_SIZE;
                        phase_next = PH_ERR;
                    end
                    PH_FORM:
                    begin
                        parse_status_next = wrhp_pkg::ST_SHORT_FORM;
                        phase_next = PH_ERR;
                    end
                    PH_PROPS:
                    begin
                        parse_status_next = wrhp_pkg::ST_SHORT_FMT;
                        phase_next = PH_ERR;
                    end
                    PH_SKIP:
                    begin
                        parse_status_next = wrhp_pkg::ST_SKIP_END;
                        phase_next = PH_ERR;
                    end
                    PH_DATA, PH_ERR:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            wrhp_pkg::CMD_RESTART:
            begin
                phase_next = PH_ID;
                byte_count_next = 4'd0;
                chunk_code_next = 32'd0;
                chunk_length_next = 32'd0;
                skip_remaining_next = 32'd0;
                for (int i = 0; i < 16; i++)
                begin
                    format_next[i] = 8'd0;
                end
                parse_status_next = wrhp_pkg::ST_HEADER;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            byte_count_reg <= 4'd0;
            chunk_code_reg <= 32'd0;
            chunk_length_reg <= 32'd0;
            skip_remaining_reg <= 32'd0;
            for (int i = 0; i < 16; i++)
            begin
                format_reg[i] <= 8'd0;
            end
            parse_status_reg <= wrhp_pkg::ST_HEADER;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            byte_count_reg <= byte_count_next;
            chunk_code_reg <= chunk_code_next;
            chunk_length_reg <= chunk_length_next;
            skip_remaining_reg <= skip_remaining_next;
            format_reg <= format_next;
            parse_status_reg <= parse_status_next;
        end
    end

    assign result.status = parse_status_next;
    assign result.audio_format = {format_next[1], format_next[0]};
    assign result.num_channels = {format_next[3], format_next[2]};
    assign result.sample_rate = {format_next[7], format_next[6], format_next[5], format_next[4]};
    assign result.byte_rate = {format_next[11], format_next[10], format_next[9], format_next[8]};
    assign result.block_align = {format_next[13], format_next[12]};
    assign result.bits_per_sample = {format_next[15], format_next[14]};
    assign result.data_size = (parse_status_next == wrhp_pkg::ST_DATA) ? chunk_length_next : 32'd0;
    assign result.payload_byte = pay ? b : 8'd0;
    assign result.payload_valid = pay;

endmodule

// ===== design/wrhp_out_reg.sv =====
// Result register that holds one result transaction until the sink takes it.
module wrhp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  wrhp_pkg::result_t result,
    output logic              ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output wrhp_pkg::result_t held
);

    logic              valid_reg;
    logic              valid_next;
    wrhp_pkg::result_t held_reg;

    assign ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign held = held_reg;

endmodule

// ===== design/wav_riff_header_parser_unit.sv =====
// Top level of the WAV header parser: input register, parser core and result register.
// An accepted input waits in the input register, its result in the result register.
// Throughput: one transaction per cycle unless the result register stalls.
// The input side stalls only while the result register is full and the sink is not ready.
// Reset (rst_n, asynchronous, active low) empties both registers and resets the parser.
// Parser state after reset is the same as after a restart command.
`include "assert_macros.svh"

module wav_riff_header_parser_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_byte
    input  logic [wrhp_pkg::BYTE_W-1:0]          s_tdata,
    // command
    input  logic [wrhp_pkg::CMD_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, audio_format, num_channels, sample_rate, byte_rate, block_align,
    // bits_per_sample, data_size, payload_byte, zero fill
    output logic [wrhp_pkg::TDATA_OUT_W-1:0]     m_tdata,
    // payload_valid
    output logic                                m_tuser
);

    logic              item_valid;
    wrhp_pkg::item_t   item;
    logic              res_ready;
    logic              step;
    wrhp_pkg::result_t result;
    wrhp_pkg::result_t held;

    assign step = item_valid && res_ready;

    wrhp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    wrhp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    wrhp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .ready    (res_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (held)
    );

    assign m_tdata = {5'd0, held.payload_byte, held.data_size, held.bits_per_sample,
                      held.block_align, held.byte_rate, held.sample_rate,
                      held.num_channels, held.audio_format, held.status};
    assign m_tuser = held.payload_valid;

    `WRHP_ASSERT_IMPLIES(a_payload_in_data, m_tvalid && held.payload_valid, held.status == wrhp_pkg::ST_DATA, "payload outside data")
    `WRHP_ASSERT_IMPLIES(a_size_in_data, m_tvalid && (held.data_size != 32'd0), held.status == wrhp_pkg::ST_DATA, "data size outside data")
    `WRHP_ASSERT_IMPLIES(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty result register")
    `WRHP_ASSERT_IMPLIES(a_step_loads, step, ##1 m_tvalid, "result lost after parser step")

endmodule

// ===== verif/tb_wav_riff_header_parser_unit.sv =====
// Self-checking testbench for the WAV header parser: directed short fields, random files and stalls.
`timescale 1ns / 1ps

module tb_wav_riff_header_parser_unit;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 9;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 750;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = 8;
    localparam logic [wrhp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        P_ID,
        P_SIZE,
        P_FORM,
        P_PROPS,
        P_SKIP,
        P_XTRA,
        P_DATA,
        P_ERR
    } parse_phase_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    // data_byte
    logic [wrhp_pkg::BYTE_W-1:0]      s_tdata;
    // command
    logic [wrhp_pkg::CMD_W-1:0]       s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    // status, audio_format, num_channels, sample_rate, byte_rate, block_align,
    // bits_per_sample, data_size, payload_byte, zero fill
    logic [wrhp_pkg::TDATA_OUT_W-1:0] m_tdata;
    // payload_valid
    logic                             m_tuser;

    parse_phase_t  parse_ph;
    logic [3:0]    field_count;
    logic [31:0]   chunk_id;
    logic [31:0]   chunk_size;
    logic [31:0]   skip_left;
    logic [127:0]  fmt_record;
    logic [2:0]    parse_stat;

    wrhp_pkg::result_t predicted_results[$];
    logic [9:0]    file_items[$];
    int            mismatch_count = 0;
    int            items_counted = 0;
    int            idle_cycles = 0;
    int            sink_hold_req = 0;
    bit            src_idle_en = 1'b1;
    bit            sink_idle_en = 1'b1;

    wav_riff_header_parser_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void clear_parser();
        parse_ph = P_ID;
        field_count = '0;
        chunk_id = '0;
        chunk_size = '0;
        skip_left = '0;
        fmt_record = '0;
        parse_stat = wrhp_pkg::ST_HEADER;
    endfunction

    function automatic wrhp_pkg::result_t parse_step(logic [wrhp_pkg::CMD_W-1:0] cmd,
                                                     logic [wrhp_pkg::BYTE_W-1:0] b);
        wrhp_pkg::result_t r;
        logic    pay;
        pay = 1'b0;
        if (cmd == wrhp_pkg::CMD_BYTE)
        begin
            case (parse_ph)
                P_ID, P_FORM:
                begin
                    chunk_id = {b, chunk_id[31:8]};
                    field_count = field_count + 4'd1;
                    if (field_count == 4'd4)
                    begin
                        field_count = '0;
                        if (parse_ph == P_ID)
                            parse_ph = P_SIZE;
                        else if (chunk_id != wrhp_pkg::ID_WAVE)
                        begin
                            parse_stat = wrhp_pkg::ST_NOT_WAVE;
                            parse_ph = P_ERR;
                        end
                        else
                            parse_ph = P_ID;
                    end
                end
                P_SIZE:
                begin
                    chunk_size = {b, chunk_size[31:8]};
                    field_count = field_count + 4'd1;
                    if (field_count == 4'd4)
                    begin
                        field_count = '0;
                        if (chunk_id == wrhp_pkg::ID_RIFF)
                            parse_ph = P_FORM;
                        else if (chunk_id == wrhp_pkg::ID_FMT)
                            parse_ph = P_PROPS;
                        else if (chunk_id == wrhp_pkg::ID_DATA)
                        begin
                            parse_ph = P_DATA;
                            parse_stat = wrhp_pkg::ST_DATA;
                        end
                        else
                        begin
                            skip_left = chunk_size;
                            parse_ph = (chunk_size == 32'd0) ? P_ID : P_SKIP;
                        end
                    end
                end
                P_PROPS:
                begin
                    fmt_record[field_count * 8 +: 8] = b;
                    if (field_count == 4'd15)
                    begin
                        field_count = '0;
                        if (chunk_size > 32'd16)
                        begin
                            skip_left = chunk_size - 32'd16;
                            parse_ph = P_XTRA;
                        end
                        else
                            parse_ph = P_ID;
                    end
                    else
                        field_count = field_count + 4'd1;
                end
                P_SKIP, P_XTRA:
                begin
                    if (skip_left != 32'd0)
                        skip_left = skip_left - 32'd1;
                    if (skip_left == 32'd0)
                        parse_ph = P_ID;
                end
                P_DATA: pay = 1'b1;
                default: ;
            endcase
        end
        else if (cmd == wrhp_pkg::CMD_END)
        begin
            case (parse_ph)
                P_ID:    parse_stat = wrhp_pkg::ST_SHORT_ID;
                P_SIZE:  parse_stat = wrhp_pkg::ST_SHORT_SIZE;
                P_FORM:  parse_stat = wrhp_pkg::ST_SHORT_FORM;
                P_PROPS: parse_stat = wrhp_pkg::ST_SHORT_FMT;
                P_SKIP:  parse_stat = wrhp_pkg::ST_SKIP_END;
                P_XTRA:  parse_stat = wrhp_pkg::ST_SHORT_ID;
                default: ;
            endcase
            if (parse_ph != P_DATA && parse_ph != P_ERR)
                parse_ph = P_ERR;
        end
        else if (cmd == wrhp_pkg::CMD_RESTART)
            clear_parser();

        r.status = parse_stat;
        r.audio_format = fmt_record[15:0];
        r.num_channels = fmt_record[31:16];
        r.sample_rate = fmt_record[63:32];
        r.byte_rate = fmt_record[95:64];
        r.block_align = fmt_record[111:96];
        r.bits_per_sample = fmt_record[127:112];
        r.data_size = (parse_stat == wrhp_pkg::ST_DATA) ? chunk_size : 32'd0;
        r.payload_byte = pay ? b : 8'd0;
        r.payload_valid = pay;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void queue_item(logic [wrhp_pkg::CMD_W-1:0] cmd,
                                       logic [wrhp_pkg::BYTE_W-1:0] b);
        file_items.push_back({cmd, b});
    endfunction

    function automatic void queue_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            queue_item(wrhp_pkg::CMD_BYTE, w[i * 8 +: 8]);
    endfunction

    function automatic void queue_bytes(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_item(wrhp_pkg::CMD_BYTE, rand_byte());
    endfunction

    function automatic void queue_riff();
        queue_word(wrhp_pkg::ID_RIFF);
        queue_word($urandom);
        queue_word(($urandom_range(0, 9) == 0) ? 32'($urandom) : wrhp_pkg::ID_WAVE);
    endfunction

    task automatic send_item(input logic [wrhp_pkg::CMD_W-1:0] cmd,
                             input logic [wrhp_pkg::BYTE_W-1:0] b);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 12) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        items_counted++;
        predicted_results.push_back(parse_step(cmd, b));
        @(negedge clk);
    endtask

    task automatic send_file();
        foreach (file_items[i])
            send_item(file_items[i][9:8], file_items[i][7:0]);
        file_items.delete();
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (predicted_results.size() != 0);
    endtask

    task automatic build_random_file();
        int unsigned n_chunks;
        int unsigned cut;
        logic [31:0] size;
        logic [31:0] id;
        bit          done;
        done = 1'b0;
        if ($urandom_range(0, 9) != 0)
            queue_item(wrhp_pkg::CMD_RESTART, rand_byte());
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 10))
                queue_item(wrhp_pkg::CMD_W'($urandom_range(0, 3)), rand_byte());
            return;
        end
        if ($urandom_range(0, 7) != 0)
            queue_riff();
        n_chunks = $urandom_range(1, 4);
        for (int unsigned c = 0; c < n_chunks && !done; c++)
        begin
            case ($urandom_range(0, 5))
                0: queue_riff();
                1, 2:
                begin
                    case ($urandom_range(0, 5))
                        0, 5: size = 32'd16;
                        1: size = 32'd18;
                        2: size = $urandom_range(0, 15);
                        3: size = $urandom_range(17, 24);
                        default: size = 32'hFFFF_FFFF;
                    endcase
                    queue_word(wrhp_pkg::ID_FMT);
                    queue_word(size);
                    queue_bytes(16);
                    if (size > 32'd64)
                    begin
                        queue_bytes($urandom_range(0, 3));
                        done = 1'b1;
                    end
                    else if (size > 32'd16)
                        queue_bytes(size - 32'd16);
                end
                3, 4:
                begin
                    id = $urandom;
                    if (id == wrhp_pkg::ID_RIFF || id == wrhp_pkg::ID_FMT ||
                        id == wrhp_pkg::ID_DATA || id == wrhp_pkg::ID_WAVE)
                        id = id ^ 32'h1;
                    size = ($urandom_range(0, 9) == 0) ? (32'($urandom) | 32'h100)
                                                       : 32'($urandom_range(0, 5));
                    queue_word(id);
                    queue_word(size);
                    if (size > 32'd64)
                    begin
                        queue_bytes($urandom_range(0, 3));
                        done = 1'b1;
                    end
                    else
                        queue_bytes(size);
                end
                default: done = 1'b1;
            endcase
        end
        if (!done || $urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                queue_word(wrhp_pkg::ID_DATA);
                queue_word($urandom);
                queue_bytes($urandom_range(0, 8));
            end
        end
        if ($urandom_range(0, 6) == 0 && file_items.size() > 1)
        begin
            cut = $urandom_range(1, file_items.size() - 1);
            while (file_items.size() > cut)
                void'(file_items.pop_back());
            queue_item(wrhp_pkg::CMD_END, rand_byte());
        end
        else if ($urandom_range(0, 1) == 0)
            queue_item(wrhp_pkg::CMD_END, rand_byte());
    endtask

    task automatic test_short_fields();
        queue_item(wrhp_pkg::CMD_RESTART, 8'h00);
        queue_item(CMD_UNUSED, 8'hFF);
        queue_item(wrhp_pkg::CMD_END, 8'h00);
        queue_item(wrhp_pkg::CMD_BYTE, 8'hFF);
        queue_item(wrhp_pkg::CMD_RESTART, 8'hFF);
        queue_word(wrhp_pkg::ID_RIFF);
        queue_item(wrhp_pkg::CMD_BYTE, 8'h00);
        queue_item(wrhp_pkg::CMD_BYTE, 8'hFF);
        queue_item(wrhp_pkg::CMD_END, 8'hFF);
        queue_item(wrhp_pkg::CMD_RESTART, 8'h00);
        queue_word(wrhp_pkg::ID_RIFF);
        queue_word(32'hFFFF_FFFF);
        queue_word(wrhp_pkg::ID_WAVE ^ 32'h8000_0000);
        send_file();
        wait_drain();
    endtask

    task automatic test_random_files();
        while (items_counted < RANDOM_ITEMS)
        begin
            src_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            build_random_file();
            send_file();
            if ($urandom_range(0, 19) == 0)
                wait_drain();
        end
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        wait_drain();
    endtask

    task automatic test_input_stall();
        src_idle_en = 1'b0;
        sink_hold_req = LONG_HOLD;
        queue_item(wrhp_pkg::CMD_RESTART, 8'h00);
        queue_riff();
        queue_word(wrhp_pkg::ID_DATA);
        queue_word($urandom);
        queue_bytes(8);
        send_file();
        src_idle_en = 1'b1;
        wait_drain();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        wrhp_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result transaction with nothing predicted");
                mismatch_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
                check_field("audio_format", 32'(want.audio_format), 32'(m_tdata[18:3]));
                check_field("num_channels", 32'(want.num_channels), 32'(m_tdata[34:19]));
                check_field("sample_rate", want.sample_rate, m_tdata[66:35]);
                check_field("byte_rate", want.byte_rate, m_tdata[98:67]);
                check_field("block_align", 32'(want.block_align), 32'(m_tdata[114:99]));
                check_field("bits_per_sample", 32'(want.bits_per_sample),
                            32'(m_tdata[130:115]));
                check_field("data_size", want.data_size, m_tdata[162:131]);
                check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[170:163]));
                check_field("payload_valid", 32'(want.payload_valid), 32'(m_tuser));
            end
        end
    end

    initial
    begin : sink_side
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (sink_hold_req != 0)
            begin
                gap = sink_hold_req;
                sink_hold_req = 0;
            end
            else
                gap = sink_idle_en ? $urandom_range(0, 12) : 0;
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = wrhp_pkg::CMD_BYTE;
        clear_parser();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_short_fields();
        test_input_stall();
        test_random_files();
        test_input_stall();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
